// File: design/bmp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_pkg
// Shared constants for the binomial coefficient modulo prime block: table
// geometry, field widths, the prime and the Barrett reduction constant.
// ----------------------------------------------------------------------------
package bmp_pkg;

    localparam int TABLE_DEPTH = 131072;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int FIELD_W     = 17;
    localparam int VALUE_W     = 30;

    localparam logic [VALUE_W-1:0] MODULUS    = 30'd1000000007;
    localparam logic [VALUE_W-1:0] FERMAT_EXP = MODULUS - 30'd2;
    localparam int                 EXP_BITS   = VALUE_W;
    localparam int                 EXP_IDX_W  = $clog2(EXP_BITS);

    // Barrett constant floor(2^60 / p); fits in 31 bits
    localparam logic [63:0] BARRETT_MU_FULL = (64'd1 << 60) / 64'(MODULUS);
    localparam logic [30:0] BARRETT_MU      = BARRETT_MU_FULL[30:0];

    // Cycles from operands in to product out of the modular multiplier
    localparam int MM_LAT = 5;

endpackage

// File: design/bmp_mulmod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_mulmod
// Five-stage pipelined multiplier modulo the prime, Barrett reduction.
// ----------------------------------------------------------------------------
module bmp_mulmod
(
    input  logic                        clk,
    input  logic                        en,
    input  logic [bmp_pkg::VALUE_W-1:0] a,
    input  logic [bmp_pkg::VALUE_W-1:0] b,
    output logic [bmp_pkg::VALUE_W-1:0] y
);

    logic [59:0] prod_reg;
    logic [61:0] q2_reg;
    logic [31:0] lo2_reg;
    logic [31:0] q3p_reg;
    logic [31:0] lo3_reg;
    logic [31:0] r_reg;
    logic [bmp_pkg::VALUE_W-1:0] y_reg;

    logic [61:0] q3p_full;
    logic [31:0] two_p;
    logic [31:0] one_p;

    assign one_p    = 32'(bmp_pkg::MODULUS);
    assign two_p    = one_p << 1;
    assign q3p_full = 62'(q2_reg[61:31]) * 62'(bmp_pkg::MODULUS);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // full product, below p^2
            prod_reg <= 60'(a) * 60'(b);
            // quotient estimate
            q2_reg   <= 62'(prod_reg[59:29]) * 62'(bmp_pkg::BARRETT_MU);
            lo2_reg  <= prod_reg[31:0];
            // only the low bits matter: the remainder is below 3p
            q3p_reg  <= q3p_full[31:0];
            lo3_reg  <= lo2_reg;
            r_reg    <= lo3_reg - q3p_reg;
            // at most two corrections
            if (r_reg >= two_p)
            begin
                y_reg <= bmp_pkg::VALUE_W'(r_reg - two_p);
            end
            else if (r_reg >= one_p)
            begin
                y_reg <= bmp_pkg::VALUE_W'(r_reg - one_p);
            end
            else
            begin
                y_reg <= bmp_pkg::VALUE_W'(r_reg);
            end
        end
    end

    assign y = y_reg;

endmodule

// File: design/binomial_mod_prime.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binomial_mod_prime
// C(n,k) modulo 1000000007 from factorial and inverse factorial tables.
// ----------------------------------------------------------------------------
// After reset the block builds its two tables before it takes any query:
// n! by a forward walk, the Fermat inverse of the largest factorial by
// square and multiply, then the inverse factorials by a backward walk. Every
// step goes through the shared five-stage modular multiplier and waits for
// its product before the next starts; the walks take 131072 and 131071 steps,
// the exponentiation at most 60. s_axis_tready stays low until the tables are
// built. From then on one query is taken every cycle while the output is not
// held. A query reads n! and the two inverse factorials from the tables and
// goes through two modular multipliers in a row into the output register. A
// query with choose above top, or top outside the table, returns coefficient
// zero with bad_query set. The whole pipeline advances together whenever the
// output register is empty or being taken, so a held output stalls the
// pipeline without losing or repeating items.
// ----------------------------------------------------------------------------
module binomial_mod_prime
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [16:0] top, [33:17] choose, rest zero

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [29:0] coefficient, rest zero
    output logic        m_axis_tuser    // [0] bad_query
);

    localparam int ADDR_W  = bmp_pkg::ADDR_W;
    localparam int VALUE_W = bmp_pkg::VALUE_W;
    localparam int FIELD_W = bmp_pkg::FIELD_W;
    localparam int MM_LAT  = bmp_pkg::MM_LAT;
    localparam int WAIT_W  = $clog2(MM_LAT + 1);
    localparam int EIDX_W  = bmp_pkg::EXP_IDX_W;

    typedef enum logic [3:0]
    {
        FILL_FWD = 4'b0001,
        FILL_POW = 4'b0010,
        FILL_BWD = 4'b0100,
        FILL_RUN = 4'b1000
    } fill_state_t;

    // ------------------------------------------------------------------
    // Tables
    // ------------------------------------------------------------------
    logic [VALUE_W-1:0] fact_mem [bmp_pkg::TABLE_DEPTH];
    logic [VALUE_W-1:0] inv_mem  [bmp_pkg::TABLE_DEPTH];

    // ------------------------------------------------------------------
    // Fill sequencer
    // ------------------------------------------------------------------
    fill_state_t        state_reg, state_next;
    logic [WAIT_W-1:0]  wait_reg,  wait_next;
    logic [ADDR_W-1:0]  idx_reg,   idx_next;
    logic [VALUE_W-1:0] acc_reg,   acc_next;
    logic [VALUE_W-1:0] base_reg,  base_next;
    logic [EIDX_W-1:0]  bit_reg,   bit_next;
    logic               sq_reg,    sq_next;

    logic               step_done;
    logic               pow_finish;
    logic               fact_we;
    logic               inv_we;
    logic [ADDR_W-1:0]  inv_waddr;
    logic [VALUE_W-1:0] fill_a;
    logic [VALUE_W-1:0] fill_b;
    logic               running;

    // Multiplier A result, shared between fill and query path
    logic [VALUE_W-1:0] mma_y;

    assign running   = (state_reg == FILL_RUN);
    assign step_done = !running && (wait_reg == WAIT_W'(MM_LAT));

    // Exponentiation is done after bit zero once its optional multiply is in
    assign pow_finish = (bit_reg == '0) &&
                        (!sq_reg || !bmp_pkg::FERMAT_EXP[bit_reg]);

    assign fact_we   = step_done && (state_reg == FILL_FWD);
    assign inv_we    = step_done && ((state_reg == FILL_BWD) ||
                                     ((state_reg == FILL_POW) && pow_finish));
    assign inv_waddr = (state_reg == FILL_POW) ? ADDR_W'(bmp_pkg::TABLE_DEPTH - 1)
                                               : idx_reg - ADDR_W'(1);

    always_comb
    begin
        fill_a = acc_reg;
        fill_b = acc_reg;
        unique case (state_reg)
            FILL_FWD:
            begin
                // entry zero takes 0! = 1
                fill_b = (idx_reg == '0) ? VALUE_W'(1) : VALUE_W'(idx_reg);
            end
            FILL_POW:
            begin
                fill_b = sq_reg ? acc_reg : base_reg;
            end
            FILL_BWD:
            begin
                fill_b = VALUE_W'(idx_reg);
            end
            FILL_RUN:
            begin
                fill_b = acc_reg;
            end
            default:
            begin
                fill_b = acc_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        wait_next  = wait_reg;
        idx_next   = idx_reg;
        acc_next   = acc_reg;
        base_next  = base_reg;
        bit_next   = bit_reg;
        sq_next    = sq_reg;

        if (!running)
        begin
            wait_next = step_done ? '0 : wait_reg + WAIT_W'(1);
        end

        if (step_done)
        begin
            unique case (state_reg)
                FILL_FWD:
                begin
                    acc_next = mma_y;
                    if (idx_reg == ADDR_W'(bmp_pkg::TABLE_DEPTH - 1))
                    begin
                        // largest factorial becomes the base to invert
                        base_next  = mma_y;
                        acc_next   = VALUE_W'(1);
                        bit_next   = EIDX_W'(bmp_pkg::EXP_BITS - 1);
                        sq_next    = 1'b1;
                        state_next = FILL_POW;
                    end
                    else
                    begin
                        idx_next = idx_reg + ADDR_W'(1);
                    end
                end
                FILL_POW:
                begin
                    acc_next = mma_y;
                    if (pow_finish)
                    begin
                        idx_next   = ADDR_W'(bmp_pkg::TABLE_DEPTH - 1);
                        state_next = FILL_BWD;
                    end
                    else if (sq_reg && bmp_pkg::FERMAT_EXP[bit_reg])
                    begin
                        sq_next = 1'b0;
                    end
                    else
                    begin
                        bit_next = bit_reg - EIDX_W'(1);
                        sq_next  = 1'b1;
                    end
                end
                FILL_BWD:
                begin
                    acc_next = mma_y;
                    if (idx_reg == ADDR_W'(1))
                    begin
                        state_next = FILL_RUN;
                    end
                    else
                    begin
                        idx_next = idx_reg - ADDR_W'(1);
                    end
                end
                FILL_RUN:
                begin
                    state_next = FILL_RUN;
                end
                default:
                begin
                    state_next = FILL_RUN;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FILL_FWD;
            wait_reg  <= '0;
            idx_reg   <= '0;
            acc_reg   <= VALUE_W'(1);
            base_reg  <= '0;
            bit_reg   <= '0;
            sq_reg    <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            wait_reg  <= wait_next;
            idx_reg   <= idx_next;
            acc_reg   <= acc_next;
            base_reg  <= base_next;
            bit_reg   <= bit_next;
            sq_reg    <= sq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fact_we)
        begin
            fact_mem[idx_reg] <= mma_y;
        end
        if (inv_we)
        begin
            inv_mem[inv_waddr] <= mma_y;
        end
    end

    // ------------------------------------------------------------------
    // Query pipeline
    // ------------------------------------------------------------------
    logic                pipe_en;
    logic                in_xfer;
    logic [FIELD_W-1:0]  in_top;
    logic [FIELD_W-1:0]  in_choose;
    logic                in_bad;

    // stage 1: captured query
    logic                v1_reg;
    logic                bad1_reg;
    logic [ADDR_W-1:0]   n1_reg;
    logic [ADDR_W-1:0]   k1_reg;
    logic [ADDR_W-1:0]   nk1_reg;

    // stage 2: table read data
    logic                v2_reg;
    logic                bad2_reg;
    logic [VALUE_W-1:0]  fact_rd_reg;
    logic [VALUE_W-1:0]  invk_rd_reg;
    logic [VALUE_W-1:0]  invnk_rd_reg;

    // side lines alongside the multipliers
    logic                va_reg    [MM_LAT];
    logic                bada_reg  [MM_LAT];
    logic [VALUE_W-1:0]  invnk_reg [MM_LAT];
    logic                vb_reg    [MM_LAT];
    logic                badb_reg  [MM_LAT];

    // output register
    logic                out_v_reg;
    logic                out_bad_reg;
    logic [VALUE_W-1:0]  out_coef_reg;

    logic [VALUE_W-1:0]  mma_a;
    logic [VALUE_W-1:0]  mma_b;
    logic [VALUE_W-1:0]  mmb_y;

    assign pipe_en       = !out_v_reg || m_axis_tready;
    assign s_axis_tready = pipe_en && running;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    assign in_top    = s_axis_tdata[FIELD_W-1:0];
    assign in_choose = s_axis_tdata[2*FIELD_W-1:FIELD_W];
    assign in_bad    = (32'(in_top) >= 32'(bmp_pkg::TABLE_DEPTH)) ||
                       (in_choose > in_top);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            out_v_reg <= 1'b0;
            for (int i = 0; i < MM_LAT; i++)
            begin
                va_reg[i] <= 1'b0;
                vb_reg[i] <= 1'b0;
            end
        end
        else if (pipe_en)
        begin
            v1_reg    <= in_xfer;
            v2_reg    <= v1_reg;
            va_reg[0] <= v2_reg;
            vb_reg[0] <= va_reg[MM_LAT-1];
            for (int i = 1; i < MM_LAT; i++)
            begin
                va_reg[i] <= va_reg[i-1];
                vb_reg[i] <= vb_reg[i-1];
            end
            out_v_reg <= vb_reg[MM_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            bad1_reg <= in_bad;
            n1_reg   <= ADDR_W'(in_top);
            k1_reg   <= ADDR_W'(in_choose);
            // wraps on a bad query; the result is forced to zero later
            nk1_reg  <= ADDR_W'(in_top - in_choose);

            bad2_reg     <= bad1_reg;
            fact_rd_reg  <= fact_mem[n1_reg];
            invk_rd_reg  <= inv_mem[k1_reg];
            invnk_rd_reg <= inv_mem[nk1_reg];

            bada_reg[0]  <= bad2_reg;
            invnk_reg[0] <= invnk_rd_reg;
            badb_reg[0]  <= bada_reg[MM_LAT-1];
            for (int i = 1; i < MM_LAT; i++)
            begin
                bada_reg[i]  <= bada_reg[i-1];
                invnk_reg[i] <= invnk_reg[i-1];
                badb_reg[i]  <= badb_reg[i-1];
            end

            out_bad_reg  <= badb_reg[MM_LAT-1];
            out_coef_reg <= badb_reg[MM_LAT-1] ? '0 : mmb_y;
        end
    end

    // Multiplier A serves the table build until the tables are ready
    assign mma_a = running ? fact_rd_reg : fill_a;
    assign mma_b = running ? invk_rd_reg : fill_b;

    bmp_mulmod u_mul_a
    (
        .clk (clk),
        .en  (pipe_en),
        .a   (mma_a),
        .b   (mma_b),
        .y   (mma_y)
    );

    bmp_mulmod u_mul_b
    (
        .clk (clk),
        .en  (pipe_en),
        .a   (mma_y),
        .b   (invnk_reg[MM_LAT-1]),
        .y   (mmb_y)
    );

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {2'b00, out_coef_reg};
    assign m_axis_tuser  = out_bad_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_no_result_during_fill: assert property (
        @(posedge clk) disable iff (!rst_n)
        !running |-> !m_axis_tvalid
    ) else $error("result presented before the tables were built");

    a_bad_gives_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0)
    ) else $error("bad query returned a nonzero coefficient");

    a_tables_frozen: assert property (
        @(posedge clk) disable iff (!rst_n)
        (fact_we || inv_we) |-> !running
    ) else $error("table written while serving queries");

endmodule
